/* src/lpmd_pkg.sv */
// Package: shared constants, tables and helpers for the point deskew pipeline.
`timescale 1ns / 1ps
package lpmd_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int TIME_WIDTH_DEF  = 64;
  localparam int TIME_BITS       = 63;

  localparam logic [31:0] ANGLE_PI      = 32'd3373259427;
  localparam logic [31:0] ANGLE_HALF_PI = 32'd1686629713;
  localparam logic [31:0] Q30_ONE       = 32'h4000_0000;

  // sine series: five divide steps, each over three stages, plus fold, square, final product
  localparam int SINE_STEPS = 5;
  localparam int SINE_LAT   = 3 * SINE_STEPS + 3;
  localparam logic [6:0]  SINE_DIV   [SINE_STEPS] = '{7'd110, 7'd72, 7'd42, 7'd20, 7'd6};
  // floor(2^32 / divisor)
  localparam logic [31:0] SINE_RECIP [SINE_STEPS] =
    '{32'd39045157, 32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};

  localparam logic [1:0] MODE_TRANS     = 2'd0;
  localparam logic [1:0] MODE_SLERP_POS = 2'd1;
  localparam logic [1:0] MODE_SLERP_NEG = 2'd2;

  typedef enum logic [2:0] {
    REG_SCAN_END   = 3'd0,
    REG_INV_SCAN   = 3'd1,
    REG_MODE       = 3'd2,
    REG_ANGLE      = 3'd3,
    REG_INV_SIN    = 3'd4,
    REG_ROT_VEC    = 3'd5,
    REG_ROT_SCALAR = 3'd6,
    REG_SHIFT      = 3'd7
  } reg_idx_t;

  function automatic logic signed [31:0] clamp_q30(input logic signed [39:0] v);
    if (v > 40'sd1073741824) begin
      return 32'sd1073741824;
    end else if (v < -40'sd1073741824) begin
      return -32'sd1073741824;
    end else begin
      return v[31:0];
    end
  endfunction

  // off-diagonal matrix entry: (a +- b) >> 29, clamped
  function automatic logic signed [31:0] mat_off(input logic signed [63:0] a,
                                                 input logic signed [63:0] b,
                                                 input logic sub);
    logic signed [64:0] s;
    s = sub ? (65'(a) - 65'(b)) : (65'(a) + 65'(b));
    return clamp_q30(40'($signed(s[64:29])));
  endfunction

  // diagonal matrix entry: 1 - (a + b) >> 29, clamped
  function automatic logic signed [31:0] mat_diag(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic signed [64:0] s;
    logic signed [39:0] d;
    s = 65'(a) + 65'(b);
    d = 40'sd1073741824 - 40'($signed(s[64:29]));
    return clamp_q30(d);
  endfunction

endpackage

/* src/lpmd_sine.sv */
// Pipelined Q2.30 sine: fold to the first quadrant, then a nested series of five divide steps.
`timescale 1ns / 1ps
module lpmd_sine import lpmd_pkg::*; (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] angle,
  output logic [30:0] sine
);

  logic [31:0] a_cl;
  logic [30:0] a_fold;
  logic [30:0] af_f, af_x;
  logic [31:0] x2_x;
  logic [61:0] sq;
  logic [61:0] fin;

  logic [31:0] x2_in [SINE_STEPS];
  logic [30:0] af_in [SINE_STEPS];
  logic [31:0] v_in  [SINE_STEPS];

  logic [31:0] v_p  [SINE_STEPS];
  logic [31:0] x2_p [SINE_STEPS];
  logic [30:0] af_p [SINE_STEPS];
  logic [31:0] v_r  [SINE_STEPS];
  logic [31:0] q_r  [SINE_STEPS];
  logic [31:0] x2_r [SINE_STEPS];
  logic [30:0] af_r [SINE_STEPS];
  logic [30:0] k_c  [SINE_STEPS];
  logic [31:0] x2_c [SINE_STEPS];
  logic [30:0] af_c [SINE_STEPS];

  always_comb begin
    a_cl   = (angle > ANGLE_PI) ? ANGLE_PI : angle;
    a_fold = (a_cl > ANGLE_HALF_PI) ? 31'(ANGLE_PI - a_cl) : a_cl[30:0];
  end

  assign sq = af_f * af_f;

  always_ff @(posedge clk) begin
    if (en) begin
      af_f <= a_fold;
      af_x <= af_f;
      x2_x <= sq[61:30];
    end
  end

  for (genvar j = 0; j < SINE_STEPS; j++) begin : g_step
    logic [63:0] rq;
    logic [31:0] qd;
    logic [31:0] rem;
    logic [31:0] qf;

    if (j == 0) begin : g_first
      assign x2_in[j] = x2_x;
      assign af_in[j] = af_x;
      assign v_in[j]  = x2_x;
    end else begin : g_next
      logic [62:0] pk;
      assign pk       = x2_c[j-1] * k_c[j-1];
      assign x2_in[j] = x2_c[j-1];
      assign af_in[j] = af_c[j-1];
      assign v_in[j]  = pk[61:30];
    end

    // quotient by reciprocal, low by at most one; fix with one compare
    assign rq  = v_p[j] * SINE_RECIP[j];
    assign qd  = 32'(q_r[j] * {25'd0, SINE_DIV[j]});
    assign rem = v_r[j] - qd;
    assign qf  = (rem >= {25'd0, SINE_DIV[j]}) ? q_r[j] + 32'd1 : q_r[j];

    always_ff @(posedge clk) begin
      if (en) begin
        v_p[j]  <= v_in[j];
        x2_p[j] <= x2_in[j];
        af_p[j] <= af_in[j];
        v_r[j]  <= v_p[j];
        q_r[j]  <= rq[63:32];
        x2_r[j] <= x2_p[j];
        af_r[j] <= af_p[j];
        k_c[j]  <= Q30_ONE[30:0] - qf[30:0];
        x2_c[j] <= x2_r[j];
        af_c[j] <= af_r[j];
      end
    end
  end

  assign fin = af_c[SINE_STEPS-1] * k_c[SINE_STEPS-1];

  always_ff @(posedge clk) begin
    if (en) begin
      sine <= fin[60:30];
    end
  end

endmodule

/* src/lidar_point_motion_deskew.sv */
// Top level: LiDAR point motion deskew with slerp rotation and scaled translation.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+---------------------------------------------
//  s_*     | in  | s_tvalid/s_tready  | tdata: x_in, y_in, z_in, point_time; tuser: point_valid
//  m_*     | out | m_tvalid/m_tready  | tdata: x_out, y_out, z_out; tuser: valid_out
//  apb     | in  | psel/penable       | 8 registers at 8*i, 64-bit data, pready tied high
//
// One point per cycle while the output is not stalled; the depth is set by the
// sine series pipeline (five divide steps of three stages each).
// Synchronous reset clears the valid bits and restores register defaults.
// When a finished point is not taken, every stage holds; s_tready follows that stall.
`timescale 1ns / 1ps
module lidar_point_motion_deskew import lpmd_pkg::*; #(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int TIME_WIDTH  = TIME_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // x_in, y_in, z_in, point_time
  input  logic [((3*COORD_WIDTH+TIME_BITS+7)/8)*8-1:0] s_tdata,
  // point_valid
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // x_out, y_out, z_out
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0] m_tdata,
  // valid_out
  output logic m_tuser,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int CW    = COORD_WIDTH;
  // width of the coordinate part above the low 16 bits
  localparam int HW    = (CW > 16) ? CW - 16 : 1;
  localparam int TW    = (TIME_WIDTH > TIME_BITS) ? TIME_BITS : TIME_WIDTH;
  localparam int L     = SINE_LAT + 8;
  localparam int SUMW  = (CW + 3 > 27) ? CW + 3 : 27;
  localparam logic [62:0] TMASK = {63{1'b1}} >> (63 - TW);
  localparam logic signed [SUMW-1:0] OMAX = {{(SUMW-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [SUMW-1:0] OMIN = ~OMAX;

  // configuration registers
  logic [62:0]        scan_end_time;
  logic [47:0]        inv_scan_length;
  logic [1:0]         rotation_mode;
  logic [31:0]        rotation_angle;
  logic [47:0]        inv_sin_angle;
  logic [62:0]        rotation_vector_part;
  logic signed [20:0] rotation_scalar_part;
  logic [62:0]        shift_vector;

  reg_idx_t ridx;
  logic     cfg_wr;

  assign pready = 1'b1;
  assign ridx   = reg_idx_t'(paddr[5:3]);
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_end_time        <= '0;
      inv_scan_length      <= '0;
      rotation_mode        <= MODE_TRANS;
      rotation_angle       <= '0;
      inv_sin_angle        <= '0;
      rotation_vector_part <= '0;
      rotation_scalar_part <= 21'sd524288;
      shift_vector         <= '0;
    end else if (cfg_wr) begin
      unique case (ridx)
        REG_SCAN_END:   scan_end_time        <= pwdata[62:0];
        REG_INV_SCAN:   inv_scan_length      <= pwdata[47:0];
        REG_MODE:       rotation_mode        <= pwdata[1:0];
        REG_ANGLE:      rotation_angle       <= pwdata[31:0];
        REG_INV_SIN:    inv_sin_angle        <= pwdata[47:0];
        REG_ROT_VEC:    rotation_vector_part <= pwdata[62:0];
        REG_ROT_SCALAR: rotation_scalar_part <= $signed(pwdata[20:0]);
        REG_SHIFT:      shift_vector         <= pwdata[62:0];
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      REG_SCAN_END:   prdata = {1'b0, scan_end_time};
      REG_INV_SCAN:   prdata = {16'd0, inv_scan_length};
      REG_MODE:       prdata = {62'd0, rotation_mode};
      REG_ANGLE:      prdata = {32'd0, rotation_angle};
      REG_INV_SIN:    prdata = {16'd0, inv_sin_angle};
      REG_ROT_VEC:    prdata = {1'b0, rotation_vector_part};
      REG_ROT_SCALAR: prdata = {43'd0, rotation_scalar_part};
      REG_SHIFT:      prdata = {1'b0, shift_vector};
    endcase
  end

  // pipeline advance
  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  logic vld_s1, vld_s2, vld_s3, vld_s4;
  logic vc [L];

  logic signed [CW-1:0] p1 [3], p2 [3], p3 [3], p4 [3];
  logic pv1, pv2, pv3, pv4;

  // S1: time difference
  logic [62:0] te, tp, diff1;
  assign te = scan_end_time & TMASK;
  assign tp = s_tdata[3*CW+62:3*CW] & TMASK;

  // S2: partial products of diff * inv_scan_length
  logic [55:0] pp_ll, pp_lh;
  logic [54:0] pp_hl, pp_hh;

  // S3: scan fraction
  logic [111:0] tprod;
  logic [30:0]  t30_s3;
  logic [30:0]  t30_c;
  assign tprod = 112'(pp_ll) + (112'(pp_lh) << 24) + (112'(pp_hl) << 32) + (112'(pp_hh) << 56);
  assign t30_c = (|tprod[111:49] || (tprod[48:18] > Q30_ONE[30:0])) ? Q30_ONE[30:0]
                                                                    : tprod[48:18];

  // S4: angle scaling and translation offsets
  logic [31:0] th;
  logic [62:0] a0p, a1p;
  logic [31:0] a0_s4, a1_s4;
  logic signed [52:0] trp [3];
  logic signed [25:0] tr4 [3];
  assign th  = (rotation_angle > ANGLE_PI) ? ANGLE_PI : rotation_angle;
  assign a0p = (Q30_ONE[30:0] - t30_s3) * th;
  assign a1p = t30_s3 * th;
  for (genvar i = 0; i < 3; i++) begin : g_tr
    assign trp[i] = $signed(shift_vector[21*i+20:21*i]) * $signed({1'b0, t30_s3});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_s1 <= 1'b0;
      vld_s2 <= 1'b0;
      vld_s3 <= 1'b0;
      vld_s4 <= 1'b0;
    end else if (en) begin
      vld_s1 <= s_tvalid;
      vld_s2 <= vld_s1;
      vld_s3 <= vld_s2;
      vld_s4 <= vld_s3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1[0] <= $signed(s_tdata[CW-1:0]);
      p1[1] <= $signed(s_tdata[2*CW-1:CW]);
      p1[2] <= $signed(s_tdata[3*CW-1:2*CW]);
      pv1   <= s_tuser;
      diff1 <= (te > tp) ? te - tp : '0;
      p2    <= p1;
      pv2   <= pv1;
      pp_ll <= diff1[31:0] * inv_scan_length[23:0];
      pp_lh <= diff1[31:0] * inv_scan_length[47:24];
      pp_hl <= diff1[62:32] * inv_scan_length[23:0];
      pp_hh <= diff1[62:32] * inv_scan_length[47:24];
      p3     <= p2;
      pv3    <= pv2;
      t30_s3 <= t30_c;
      p4     <= p3;
      pv4    <= pv3;
      a0_s4  <= a0p[61:30];
      a1_s4  <= a1p[61:30];
      for (int i = 0; i < 3; i++) begin
        tr4[i] <= trp[i][52:27];
      end
    end
  end

  // side data travels with the point through the sine and rotation stages
  logic signed [CW-1:0] dp  [L][3];
  logic signed [25:0]   dtr [L][3];
  logic                 dpv [L];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < L; s++) begin
        vc[s] <= 1'b0;
      end
    end else if (en) begin
      vc[0] <= vld_s4;
      for (int s = 1; s < L; s++) begin
        vc[s] <= vc[s-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dp[0]  <= p4;
      dtr[0] <= tr4;
      dpv[0] <= pv4;
      for (int s = 1; s < L; s++) begin
        dp[s]  <= dp[s-1];
        dtr[s] <= dtr[s-1];
        dpv[s] <= dpv[s-1];
      end
    end
  end

  logic [30:0] sin0, sin1;

  lpmd_sine u_sine0 (
    .clk   (clk),
    .en    (en),
    .angle (a0_s4),
    .sine  (sin0)
  );

  lpmd_sine u_sine1 (
    .clk   (clk),
    .en    (en),
    .angle (a1_s4),
    .sine  (sin1)
  );

  // C1/C2: weights
  logic [62:0] cp_lo0, cp_lo1;
  logic [46:0] cp_hi0, cp_hi1;
  logic [79:0] cs0, cs1;
  logic [31:0] c0_c2;
  logic signed [32:0] c1s_c2;
  logic [31:0] c0_n, c1_n;
  assign cs0  = 80'(cp_lo0) + (80'(cp_hi0) << 32);
  assign cs1  = 80'(cp_lo1) + (80'(cp_hi1) << 32);
  assign c0_n = (|cs0[79:48]) ? 32'hFFFF_FFFF : cs0[47:16];
  assign c1_n = (|cs1[79:48]) ? 32'hFFFF_FFFF : cs1[47:16];

  // Q1/Q2: interpolated quaternion
  logic signed [53:0] qp [4];
  logic [31:0]        c0_q1;
  logic signed [31:0] q [4];
  logic signed [34:0] qs [4];
  logic signed [36:0] wsum;
  logic signed [20:0] q1v [4];
  assign q1v[0] = $signed(rotation_vector_part[20:0]);
  assign q1v[1] = $signed(rotation_vector_part[41:21]);
  assign q1v[2] = $signed(rotation_vector_part[62:42]);
  assign q1v[3] = rotation_scalar_part;
  for (genvar i = 0; i < 4; i++) begin : g_qs
    assign qs[i] = $signed(qp[i][53:19]);
  end
  assign wsum = $signed({5'd0, c0_q1}) + 37'(qs[3]);

  // M1/M2: rotation matrix
  logic signed [63:0] mp [9];
  logic signed [31:0] rm [9];

  // D1/D2: matrix times point
  logic signed [HW+31:0] dh [9];
  logic signed [48:0]    dl [9];
  logic signed [CW+1:0]  res [3];
  logic signed [CW+17:0] sa [3];
  logic signed [50:0]    sb [3];
  logic signed [CW+34:0] tt [3];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sa[r] = (CW+18)'(dh[3*r]) + (CW+18)'(dh[3*r+1]) + (CW+18)'(dh[3*r+2]);
      sb[r] = 51'(dl[3*r]) + 51'(dl[3*r+1]) + 51'(dl[3*r+2]);
      tt[r] = ((CW+35)'(sa[r]) <<< 16) + (CW+35)'(sb[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cp_lo0 <= sin0 * inv_sin_angle[31:0];
      cp_hi0 <= sin0 * inv_sin_angle[47:32];
      cp_lo1 <= sin1 * inv_sin_angle[31:0];
      cp_hi1 <= sin1 * inv_sin_angle[47:32];
      c0_c2  <= c0_n;
      c1s_c2 <= (rotation_mode == MODE_SLERP_NEG) ? -$signed({1'b0, c1_n})
                                                  : $signed({1'b0, c1_n});
      c0_q1  <= c0_c2;
      for (int i = 0; i < 4; i++) begin
        qp[i] <= c1s_c2 * q1v[i];
      end
      for (int i = 0; i < 3; i++) begin
        q[i] <= clamp_q30(40'(qs[i]));
      end
      q[3]  <= clamp_q30(40'(wsum));
      mp[0] <= q[0] * q[0];
      mp[1] <= q[1] * q[1];
      mp[2] <= q[2] * q[2];
      mp[3] <= q[0] * q[1];
      mp[4] <= q[0] * q[2];
      mp[5] <= q[1] * q[2];
      mp[6] <= q[0] * q[3];
      mp[7] <= q[1] * q[3];
      mp[8] <= q[2] * q[3];
      rm[0] <= mat_diag(mp[1], mp[2]);
      rm[1] <= mat_off(mp[3], mp[8], 1'b1);
      rm[2] <= mat_off(mp[4], mp[7], 1'b0);
      rm[3] <= mat_off(mp[3], mp[8], 1'b0);
      rm[4] <= mat_diag(mp[0], mp[2]);
      rm[5] <= mat_off(mp[5], mp[6], 1'b1);
      rm[6] <= mat_off(mp[4], mp[7], 1'b1);
      rm[7] <= mat_off(mp[5], mp[6], 1'b0);
      rm[8] <= mat_diag(mp[0], mp[1]);
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          dh[3*r+c] <= rm[3*r+c] * $signed(HW'(dp[L-3][c] >>> 16));
          dl[3*r+c] <= rm[3*r+c] * $signed({1'b0, dp[L-3][c][15:0]});
        end
      end
      for (int r = 0; r < 3; r++) begin
        res[r] <= $signed(tt[r][CW+31:30]);
      end
    end
  end

  // output stage: translate, saturate, pass invalid points through
  logic                  rot;
  logic signed [SUMW-1:0] osum [3];
  logic signed [CW-1:0]   onext [3];
  logic signed [CW-1:0]   ocoord [3];
  logic                   ovalid;

  assign rot = (rotation_mode == MODE_SLERP_POS) || (rotation_mode == MODE_SLERP_NEG);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      osum[i] = (rot ? SUMW'(res[i]) : SUMW'(dp[L-1][i])) + SUMW'(dtr[L-1][i]);
      priority if (!dpv[L-1]) begin
        onext[i] = dp[L-1][i];
      end else if (osum[i] > OMAX) begin
        onext[i] = OMAX[CW-1:0];
      end else if (osum[i] < OMIN) begin
        onext[i] = OMIN[CW-1:0];
      end else begin
        onext[i] = osum[i][CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vc[L-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ocoord <= onext;
      ovalid <= dpv[L-1];
    end
  end

  always_comb begin
    m_tdata             = '0;
    m_tdata[CW-1:0]     = ocoord[0];
    m_tdata[2*CW-1:CW]  = ocoord[1];
    m_tdata[3*CW-1:2*CW] = ocoord[2];
  end
  assign m_tuser = ovalid;

  // a stalled output freezes the whole pipeline
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> ($stable(vld_s1) && $stable(vc[L-1]) && $stable(vld_s4)))
    else $error("pipeline moved during output stall");

  // a point at the end of the pipeline reaches the output register
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (vc[L-1] && en) |=> m_tvalid)
    else $error("point lost before output register");

  // scan fraction never exceeds one
  a_t_cap: assert property (@(posedge clk) disable iff (rst)
    vld_s4 |-> (t30_s3 <= Q30_ONE[30:0]))
    else $error("scan fraction above one");

endmodule

/* bench/testbench.sv */
// Testbench for the LiDAR point deskew block: directed and random points checked against a predictor.
`timescale 1ns / 1ps
module testbench;
  import lpmd_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic               v;
  } point_out_t;

  typedef struct {
    logic signed [31:0] x, y, z;
    logic [62:0]        ts;
    logic               v;
    logic               typed;   // expected value given in the row
    point_out_t         want;
  } point_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [159:0] s_tdata = '0;  // x_in[31:0], y_in[63:32], z_in[95:64], point_time[158:96]
  logic s_tuser = 1'b0;        // point_valid
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;        // x_out[31:0], y_out[63:32], z_out[95:64]
  logic m_tuser;               // valid_out
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0] paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic pready;

  lidar_point_motion_deskew u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // predictor copy of the registers
  logic [62:0] scan_end;
  logic [47:0] inv_scan;
  logic [1:0]  mode;
  logic [31:0] angle;
  logic [47:0] inv_sin;
  logic [62:0] quat_vec;
  logic [20:0] quat_w;
  logic [62:0] shift_vec;

  point_out_t deskewed_q[$];
  int  errors = 0;
  bit  no_gaps = 1'b0;

  task automatic report(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    errors++;
  endtask

  function automatic longint sx21(input logic [62:0] v, input int lsb);
    logic [20:0] f;
    f = 21'(v >> lsb);
    return longint'($signed(f));
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic logic [63:0] mul_floor_cap(input logic [63:0] a, input logic [63:0] b,
                                                input int s, input logic [63:0] cap);
    logic [127:0] p;
    p = ({64'd0, a} * {64'd0, b}) >> s;
    return (p > {64'd0, cap}) ? cap : p[63:0];
  endfunction

  function automatic logic [63:0] sine_series(input logic [63:0] a);
    logic [63:0] one, x2, k;
    one = 64'd1 << 30;
    if (a > ANGLE_PI) a = ANGLE_PI;
    if (a > ANGLE_HALF_PI) a = ANGLE_PI - a;
    x2 = (a * a) >> 30;
    k = one - x2 / 110;
    k = one - ((x2 * k) >> 30) / 72;
    k = one - ((x2 * k) >> 30) / 42;
    k = one - ((x2 * k) >> 30) / 20;
    k = one - ((x2 * k) >> 30) / 6;
    return (a * k) >> 30;
  endfunction

  function automatic point_out_t deskew_point(input logic signed [31:0] px,
                                              input logic signed [31:0] py,
                                              input logic signed [31:0] pz,
                                              input logic [62:0] ts, input logic pv);
    point_out_t o;
    longint p[3], res[3], rm[9];
    longint t30, c0, c1, qx, qy, qz, qw, xx, yy, zz, xy, xz, yz, xw, yw, zw, sh, v;
    logic [63:0] diff, th, a0, a1;
    logic signed [127:0] acc, rr, pp;
    longint one;
    one = longint'(1) << 30;
    p[0] = px; p[1] = py; p[2] = pz;
    o.v = pv;
    if (!pv) begin
      o.x = px; o.y = py; o.z = pz;
      return o;
    end
    diff = (scan_end > ts) ? {1'b0, scan_end - ts} : 64'd0;
    t30 = longint'(mul_floor_cap(diff, {16'd0, inv_scan}, 18, 64'd1 << 30));
    if (mode == MODE_SLERP_POS || mode == MODE_SLERP_NEG) begin
      th = (angle > ANGLE_PI) ? ANGLE_PI : angle;
      a0 = (64'(one - t30) * th) >> 30;
      a1 = (64'(t30) * th) >> 30;
      c0 = longint'(mul_floor_cap(sine_series(a0), {16'd0, inv_sin}, 16, 64'hFFFF_FFFF));
      c1 = longint'(mul_floor_cap(sine_series(a1), {16'd0, inv_sin}, 16, 64'hFFFF_FFFF));
      if (mode == MODE_SLERP_NEG) c1 = -c1;
      qx = clip((c1 * sx21(quat_vec, 0)) >>> 19, -one, one);
      qy = clip((c1 * sx21(quat_vec, 21)) >>> 19, -one, one);
      qz = clip((c1 * sx21(quat_vec, 42)) >>> 19, -one, one);
      qw = clip(c0 + ((c1 * longint'($signed(quat_w))) >>> 19), -one, one);
      xx = qx * qx; yy = qy * qy; zz = qz * qz;
      xy = qx * qy; xz = qx * qz; yz = qy * qz;
      xw = qx * qw; yw = qy * qw; zw = qz * qw;
      rm[0] = one - ((yy + zz) >>> 29);
      rm[1] = (xy - zw) >>> 29;
      rm[2] = (xz + yw) >>> 29;
      rm[3] = (xy + zw) >>> 29;
      rm[4] = one - ((xx + zz) >>> 29);
      rm[5] = (yz - xw) >>> 29;
      rm[6] = (xz - yw) >>> 29;
      rm[7] = (yz + xw) >>> 29;
      rm[8] = one - ((xx + yy) >>> 29);
      for (int i = 0; i < 9; i++) rm[i] = clip(rm[i], -one, one);
      for (int r = 0; r < 3; r++) begin
        acc = 0;
        for (int c = 0; c < 3; c++) begin
          rr = rm[3 * r + c];
          pp = p[c];
          acc = acc + rr * pp;
        end
        res[r] = longint'(acc >>> 30);
      end
    end else begin
      res = p;
    end
    for (int i = 0; i < 3; i++) begin
      sh = sx21(shift_vec, 21 * i);
      v = clip(res[i] + ((sh * t30) >>> 27), -64'sd2147483648, 64'sd2147483647);
      p[i] = v;
    end
    o.x = p[0][31:0]; o.y = p[1][31:0]; o.z = p[2][31:0];
    return o;
  endfunction

  task automatic write_reg(input reg_idx_t idx, input logic [63:0] val);
    case (idx)
      REG_SCAN_END:   scan_end  = val[62:0];
      REG_INV_SCAN:   inv_scan  = val[47:0];
      REG_MODE:       mode      = val[1:0];
      REG_ANGLE:      angle     = val[31:0];
      REG_INV_SIN:    inv_sin   = val[47:0];
      REG_ROT_VEC:    quat_vec  = val[62:0];
      REG_ROT_SCALAR: quat_w    = val[20:0];
      REG_SHIFT:      shift_vec = val[62:0];
      default: ;
    endcase
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic send_point(input logic signed [31:0] px, input logic signed [31:0] py,
                            input logic signed [31:0] pz, input logic [62:0] ts,
                            input logic pv, input logic typed, input point_out_t want);
    int gap;
    point_out_t got;
    gap = no_gaps ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, ts, pz, py, px};
    s_tuser <= pv;
    do @(negedge clk); while (!s_tready);
    got = deskew_point(px, py, pz, ts, pv);
    if (typed && got != want) report("typed row disagrees with predictor");
    deskewed_q.push_back(typed ? want : got);
    @(posedge clk);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (deskewed_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return $signed($urandom());
      1: return $signed(32'($urandom_range(0, 32'h00FF_FFFF)) - 32'h0080_0000);
      2: return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
      default: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sd524288;
    endcase
  endfunction

  // timestamps mostly inside the scan window, some after it, some anywhere
  function automatic logic [62:0] rand_stamp(input logic [63:0] span);
    logic [63:0] d;
    case ($urandom_range(0, 7))
      0: return {31'($urandom()), $urandom()};
      1: return scan_end + $urandom_range(1, 1000);
      default: begin
        d = {$urandom(), $urandom()} % (span + span / 4 + 1);
        return (d[62:0] <= scan_end) ? scan_end - d[62:0] : {31'($urandom()), $urandom()};
      end
    endcase
  endfunction

  task automatic random_setup(input logic [1:0] m);
    logic [63:0] span;
    span = 64'($urandom_range(1, 1 << 27));
    write_reg(REG_SCAN_END, {1'b0, 31'($urandom()), $urandom()});
    write_reg(REG_INV_SCAN, (64'd1 << 48) / span);
    write_reg(REG_MODE, 64'(m));
    write_reg(REG_ANGLE, 64'($urandom_range(0, ANGLE_PI)));
    write_reg(REG_INV_SIN, 64'($urandom_range(32'h0001_0000, 32'h0010_0000)));
    write_reg(REG_ROT_VEC, {1'b0, 31'($urandom()), $urandom()});
    write_reg(REG_ROT_SCALAR, 64'($urandom_range(0, 32'h1F_FFFF)));
    write_reg(REG_SHIFT, {1'b0, 31'($urandom()), $urandom()});
  endtask

  // output side: random stalls, check each beat against the oldest expectation
  initial begin
    int stall;
    point_out_t exp_pt;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(negedge clk); while (!m_tvalid);
      if (deskewed_q.size() == 0) begin
        report("result beat with nothing expected");
      end else begin
        exp_pt = deskewed_q.pop_front();
        if ($signed(m_tdata[31:0]) != exp_pt.x)
          report($sformatf("x_out %0d, want %0d", $signed(m_tdata[31:0]), exp_pt.x));
        if ($signed(m_tdata[63:32]) != exp_pt.y)
          report($sformatf("y_out %0d, want %0d", $signed(m_tdata[63:32]), exp_pt.y));
        if ($signed(m_tdata[95:64]) != exp_pt.z)
          report($sformatf("z_out %0d, want %0d", $signed(m_tdata[95:64]), exp_pt.z));
        if (m_tuser != exp_pt.v)
          report($sformatf("valid_out %0b, want %0b", m_tuser, exp_pt.v));
      end
      @(posedge clk);
    end
  end

  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    point_row_t rows[$];
    point_row_t r;
    point_out_t none;
    logic [1:0] mlist[4];
    logic [63:0] span;
    none = '0;
    scan_end = '0; inv_scan = '0; mode = MODE_TRANS; angle = '0;
    inv_sin = '0; quat_vec = '0; quat_w = 21'd524288; shift_vec = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // after reset the scan fraction is zero, so points pass unchanged
    rows.push_back('{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 63'd0, 1'b1, 1'b1,
                     '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd0, 1'b1}});
    rows.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, {63{1'b1}}, 1'b1, 1'b1,
                     '{32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd1, 1'b1}});
    rows.push_back('{32'sh1234_5678, -32'sd65536, 32'sd65536, 63'd77, 1'b0, 1'b1,
                     '{32'sh1234_5678, -32'sd65536, 32'sd65536, 1'b0}});
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].ts, rows[i].v,
                                 rows[i].typed, rows[i].want);
    rows.delete();
    wait_idle();

    // every register at its extreme, negative slerp
    write_reg(REG_SCAN_END, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(REG_INV_SCAN, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_MODE, 64'(MODE_SLERP_NEG));
    write_reg(REG_ANGLE, 64'hFFFF_FFFF);
    write_reg(REG_INV_SIN, 64'hFFFF_FFFF_FFFF);
    write_reg(REG_ROT_VEC, 64'h7FFF_FFFF_FFFF_FFFF);
    write_reg(REG_ROT_SCALAR, 64'h10_0000);
    write_reg(REG_SHIFT, 64'h7FFF_FFFF_FFFF_FFFF);
    r = '{32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh8000_0000, 63'd0, 1'b1, 1'b0, none};
    rows.push_back(r);                       // long scan fraction saturates to one
    r.ts = {63{1'b1}}; rows.push_back(r);    // stamp at scan end
    r.x = 32'sd65536; r.y = -32'sd65536; r.z = 32'sd0;
    r.ts = scan_end - 63'd1; rows.push_back(r);
    r.v = 1'b0; rows.push_back(r);           // invalid point with rotation active
    foreach (rows[i]) send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].ts, rows[i].v,
                                 1'b0, none);
    rows.delete();
    wait_idle();

    // each mode once with a moderate scan, including the unused code
    mlist = '{MODE_TRANS, MODE_SLERP_POS, MODE_SLERP_NEG, MODE_UNUSED};
    foreach (mlist[m]) begin
      random_setup(mlist[m]);
      write_reg(REG_SCAN_END, 64'd1_000_000);
      write_reg(REG_INV_SCAN, (64'd1 << 48) / 64'd500_000);
      send_point(32'sd655360, -32'sd327680, 32'sd131072, 63'd1_000_000, 1'b1, 1'b0, none);
      send_point(32'sd655360, -32'sd327680, 32'sd131072, 63'd750_000, 1'b1, 1'b0, none);
      send_point(32'sd655360, -32'sd327680, 32'sd131072, 63'd400_000, 1'b1, 1'b0, none);
      send_point(32'sd655360, -32'sd327680, 32'sd131072, 63'd2_000_000, 1'b1, 1'b0, none);
      wait_idle();
    end

    // random phases; zero-angle, max inverse-sine and burst phases among them
    for (int ph = 0; ph < 12; ph++) begin
      random_setup(logic'(ph % 4 == 3) ? MODE_UNUSED : 2'(ph % 3));
      if (ph == 4) write_reg(REG_ANGLE, 64'd0);
      if (ph == 5) write_reg(REG_ANGLE, 64'(ANGLE_PI));
      if (ph == 6) write_reg(REG_INV_SIN, 64'hFFFF_FFFF_FFFF);
      if (ph == 7) write_reg(REG_INV_SCAN, 64'd0);
      if (ph == 8) write_reg(REG_ROT_SCALAR, 64'hF_FFFF);
      no_gaps = (ph % 4 == 1);
      span = (64'd1 << 48) / (inv_scan == 0 ? 64'd1 : {16'd0, inv_scan});
      for (int n = 0; n < 52; n++)
        send_point(rand_coord(), rand_coord(), rand_coord(), rand_stamp(span),
                   $urandom_range(0, 9) != 0, 1'b0, none);
      wait_idle();
      no_gaps = 1'b0;
    end

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
